// File: design/pstt_pkg.sv
package pstt_pkg;

   localparam int DEPTH         = 16;
   localparam int KEY_BITS      = 64;
   localparam int PRIORITY_BITS = 8;
   localparam int IDX_W         = $clog2(DEPTH);
   localparam int CNT_W         = $clog2(DEPTH + 1);

   // request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;

   // status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   // control broadcast to every cell of the row
   typedef struct packed {
      logic capture;    // latch compare flags against the incoming word
      logic shift_in;   // insert: open a gap, take left neighbour or new entry
      logic shift_out;  // delete: close the gap, take right neighbour
   } ctl_type;

endpackage

// File: design/pstt_cell.sv
module pstt_cell (
   input  logic                                 clock,
   input  pstt_pkg::ctl_type                    ctl,
   input  logic                                 valid,
   input  logic [pstt_pkg::KEY_BITS-1:0]        cmp_key,
   input  logic [pstt_pkg::PRIORITY_BITS-1:0]   cmp_prio,
   input  logic [pstt_pkg::KEY_BITS-1:0]        new_key,
   input  logic [pstt_pkg::PRIORITY_BITS-1:0]   new_prio,
   input  logic [pstt_pkg::KEY_BITS-1:0]        left_key,
   input  logic [pstt_pkg::PRIORITY_BITS-1:0]   left_prio,
   input  logic [pstt_pkg::KEY_BITS-1:0]        right_key,
   input  logic [pstt_pkg::PRIORITY_BITS-1:0]   right_prio,
   input  logic                                 left_ge,
   input  logic                                 seen_in,
   output logic [pstt_pkg::KEY_BITS-1:0]        key,
   output logic [pstt_pkg::PRIORITY_BITS-1:0]   prio,
   output logic                                 ge,
   output logic                                 seen_out,
   output logic                                 first
);
   import pstt_pkg::*;

   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic                     ge_ff, ge_in;
   logic                     match_ff, match_in;

   // empty slots count as "lower or equal" so the insert point is monotone
   always_comb begin
      ge_in    = ge_ff;
      match_in = match_ff;
      if (ctl.capture) begin
         ge_in    = !valid || (prio_ff <= cmp_prio);
         match_in = valid && (key_ff == cmp_key);
      end
   end

   assign seen_out = seen_in | match_ff;
   assign first    = match_ff & !seen_in;

   always_comb begin
      key_in  = key_ff;
      prio_in = prio_ff;
      if (ctl.shift_in && ge_ff) begin
         if (left_ge) begin
            key_in  = left_key;
            prio_in = left_prio;
         end else begin
            key_in  = new_key;
            prio_in = new_prio;
         end
      end else if (ctl.shift_out && seen_out) begin
         key_in  = right_key;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      prio_ff  <= prio_in;
      ge_ff    <= ge_in;
      match_ff <= match_in;
   end

   assign key  = key_ff;
   assign prio = prio_ff;
   assign ge   = ge_ff;

endmodule

// File: design/priority_sorted_task_table.sv
// Priority-sorted task table: up to DEPTH entries (key, priority) held in
// descending priority order in a row of cells.
// Request channel: present req_type, req_item_key and req_item_priority
// with start; the word is taken at the clock edge where start is high and
// busy is low. Insert places the entry before the first one of lower or
// equal priority, delete removes the first key match and closes the gap,
// lookup reports the first key match.
// Response channel: rsp_strobe is high for exactly one cycle with status,
// found_index, found_priority and stored_count; the receiver cannot stall,
// so the word must be taken in that cycle.
// Timing: compare flags are latched in every cell at the accepting edge;
// the next cycle (busy high) ripples the first-match chain along the row,
// shifts the cells and registers the response, which appears in the cycle
// after that. A new word is not accepted while busy is high.
// Reset clears the entry count, busy and the strobe; cell contents are
// left as they are and count as empty.
module priority_sorted_task_table (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_type,
   input  logic [pstt_pkg::KEY_BITS-1:0]        req_item_key,
   input  logic [pstt_pkg::PRIORITY_BITS-1:0]   req_item_priority,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_status,
   output logic [3:0]                           rsp_found_index,
   output logic [7:0]                           rsp_found_priority,
   output logic [4:0]                           rsp_stored_count
);
   import pstt_pkg::*;

   logic                     accept;
   logic                     busy_ff, busy_in;
   logic [1:0]               op_ff;
   logic [KEY_BITS-1:0]      key_ff;
   logic [PRIORITY_BITS-1:0] prio_ff;
   logic [CNT_W-1:0]         count_ff, count_in;

   logic                     strobe_ff, strobe_in;
   logic [1:0]               status_ff, status_in;
   logic [IDX_W-1:0]         index_ff, index_in;
   logic [PRIORITY_BITS-1:0] fprio_ff, fprio_in;

   ctl_type                  ctl;
   logic                     full, found, do_insert, do_delete;

   logic [KEY_BITS-1:0]      cell_key  [DEPTH];
   logic [PRIORITY_BITS-1:0] cell_prio [DEPTH];
   logic [DEPTH-1:0]         cell_ge, cell_first, cell_valid;
   logic [DEPTH:0]           seen;

   logic [CNT_W-1:0]         ins_pos;
   logic [IDX_W-1:0]         hit_idx;
   logic [PRIORITY_BITS-1:0] hit_prio;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // hold the request for the execute cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_type;
         key_ff  <= req_item_key;
         prio_ff <= req_item_priority;
      end
   end

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign found     = seen[DEPTH];
   assign do_insert = busy_ff && (op_ff == REQ_INSERT) && !full;
   assign do_delete = busy_ff && (op_ff == REQ_DELETE) && found;

   assign ctl.capture   = accept;
   assign ctl.shift_in  = do_insert;
   assign ctl.shift_out = do_delete;

   assign seen[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0]      lk, rk;
      logic [PRIORITY_BITS-1:0] lp, rp;
      logic                     lge;

      assign cell_valid[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign lk  = key_ff;
         assign lp  = prio_ff;
         assign lge = 1'b0;
      end else begin : g_body
         assign lk  = cell_key[i-1];
         assign lp  = cell_prio[i-1];
         assign lge = cell_ge[i-1];
      end

      // the tail takes itself on delete: the slot falls outside the count
      if (i == DEPTH - 1) begin : g_tail
         assign rk = cell_key[i];
         assign rp = cell_prio[i];
      end else begin : g_mid
         assign rk = cell_key[i+1];
         assign rp = cell_prio[i+1];
      end

      pstt_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .valid      (cell_valid[i]),
         .cmp_key    (req_item_key),
         .cmp_prio   (req_item_priority),
         .new_key    (key_ff),
         .new_prio   (prio_ff),
         .left_key   (lk),
         .left_prio  (lp),
         .right_key  (rk),
         .right_prio (rp),
         .left_ge    (lge),
         .seen_in    (seen[i]),
         .key        (cell_key[i]),
         .prio       (cell_prio[i]),
         .ge         (cell_ge[i]),
         .seen_out   (seen[i+1]),
         .first      (cell_first[i])
      );
   end

   // ge flags run false..true along the row, so the insert point is the
   // number of cells that stay put
   assign ins_pos = CNT_W'($countones(~cell_ge));

   always_comb begin
      hit_idx  = '0;
      hit_prio = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_first[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_prio = hit_prio | cell_prio[i];
         end
      end
   end

   always_comb begin
      busy_in   = accept;
      strobe_in = busy_ff;
      count_in  = count_ff;
      status_in = ST_DONE;
      index_in  = '0;
      fprio_in  = '0;
      if (busy_ff) begin
         unique case (op_ff)
            REQ_INSERT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  index_in = ins_pos[IDX_W-1:0];
                  count_in = count_ff + CNT_W'(1);
               end
            end
            REQ_DELETE: begin
               if (found) begin
                  index_in = hit_idx;
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
            REQ_LOOKUP: begin
               if (found) begin
                  index_in = hit_idx;
                  fprio_in = hit_prio;
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
            default: begin
               // unused request: report the count, change nothing
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
         count_ff  <= count_in;
      end
   end

   // response word, valid only with the strobe
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         status_ff <= status_in;
         index_ff  <= index_in;
         fprio_ff  <= fprio_in;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_index    = index_ff;
   assign rsp_found_priority = fprio_ff;
   assign rsp_stored_count   = count_ff;

endmodule
